/* rtl/led_matrix_scan_driver_core_assert.svh */
`ifndef LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LMSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lmsd_pkg.sv */
package lmsd_pkg;

  localparam int PANEL_COLUMNS = 32;
  localparam int SCAN_ROWS     = 16;
  localparam int PANEL_ROWS    = 2 * SCAN_ROWS;

  localparam int COL_W     = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
  localparam int ROW_W     = $clog2(SCAN_ROWS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CNT_W     = $clog2(PANEL_COLUMNS + 1);

  localparam int IN_ROW_W    = 5;
  localparam int IN_COL_W    = 5;
  localparam int COLOR_W     = 3;
  localparam int ROW_ADDR_W  = 4;
  localparam int DWELL_W     = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1000;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TICKS = 1'b1;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_DWELL    = 3'd1,
    PH_DATA     = 3'd2,
    PH_CLOCK    = 3'd3,
    PH_LATCH_HI = 3'd4,
    PH_LATCH_LO = 3'd5,
    PH_OE_RISE  = 3'd6
  } phase_t;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic   en;
    logic   lower;
    addr_t  addr;
    color_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

endpackage

/* rtl/lmsd_if.sv */
interface lmsd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [4:0] pixel_row;
  logic [4:0] pixel_column;
  logic [2:0] pixel_color;

  modport source (output valid, output func, output pixel_row, output pixel_column,
                  output pixel_color, input ready);
  modport sink (input valid, input func, input pixel_row, input pixel_column,
                input pixel_color, output ready);
endinterface

interface lmsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_address;
  logic [2:0] upper_rgb;
  logic [2:0] lower_rgb;
  logic       shift_clock;
  logic       latch_strobe;
  logic       output_enable;
  logic       row_finished;

  modport source (output valid, output row_address, output upper_rgb, output lower_rgb,
                  output shift_clock, output latch_strobe, output output_enable,
                  output row_finished, input ready);
  modport sink (input valid, input row_address, input upper_rgb, input lower_rgb,
                input shift_clock, input latch_strobe, input output_enable,
                input row_finished, output ready);
endinterface

/* rtl/lmsd_frame_mem.sv */
module lmsd_frame_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  lmsd_pkg::mem_wr_t wr,
  input  lmsd_pkg::mem_rd_t rd,
  output lmsd_pkg::color_t  rd_upper,
  output lmsd_pkg::color_t  rd_lower,
  output logic              busy
);

  lmsd_pkg::color_t upper_mem [lmsd_pkg::MEM_DEPTH];
  lmsd_pkg::color_t lower_mem [lmsd_pkg::MEM_DEPTH];

  lmsd_pkg::color_t rd_upper_r;
  lmsd_pkg::color_t rd_lower_r;
  lmsd_pkg::addr_t  clr_addr_r;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + lmsd_pkg::ADDR_W'(1);
      if (clr_addr_r == '1) begin
        busy_r <= 1'b0;
      end
    end
  end

  // clear both halves, then take pixel writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      upper_mem[clr_addr_r] <= '0;
      lower_mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      if (wr.lower) begin
        lower_mem[wr.addr] <= wr.data;
      end else begin
        upper_mem[wr.addr] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_upper_r <= upper_mem[rd.addr];
      rd_lower_r <= lower_mem[rd.addr];
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;
  assign busy     = busy_r;

endmodule

/* rtl/led_matrix_scan_driver_core.sv */
// channel   dir  handshake          payload
// in_ch     in   valid/ready        func, pixel_row, pixel_column, pixel_color
// out_ch    out  valid/ready        row_address, upper_rgb, lower_rgb, shift_clock,
//                                   latch_strobe, output_enable, row_finished
// cfg_*     in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One item per cycle while in_ch is ready: each pixel write or tick gives one result in the next cycle.
// Column data comes from a frame memory read issued at transfer, registered and ready in the next cycle.
// After reset the frame memory clears its SCAN_ROWS * 2**COL_W addresses (512), in_ch not ready.
// A stalled result holds out_ch and drops in_ch.ready; config is taken at any time.
`include "led_matrix_scan_driver_core_assert.svh"

module led_matrix_scan_driver_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lmsd_in_if.sink                              in_ch,
  lmsd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lmsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lmsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic                               scan_en_r;
  logic [lmsd_pkg::DWELL_W-1:0]       dwell_ticks_r;

  lmsd_pkg::phase_t                   phase_r, phase_nxt;
  logic [lmsd_pkg::ROW_W-1:0]         scan_row_r, scan_row_nxt;
  logic [lmsd_pkg::CNT_W-1:0]         col_cnt_r, col_cnt_nxt;
  logic [lmsd_pkg::DWELL_W-1:0]       dwell_r, dwell_nxt;
  logic [lmsd_pkg::ROW_W-1:0]         row_addr_r, row_addr_nxt;
  logic                               clk_pin_r, clk_pin_nxt;
  logic                               lat_pin_r, lat_pin_nxt;
  logic                               oe_pin_r, oe_pin_nxt;
  logic                               rgb_live_r, rgb_live_nxt;
  logic                               finished_r, finished_nxt;
  logic                               out_valid_r;

  logic                               accept;
  logic                               tick_acc;
  logic                               present;
  logic                               mem_busy;
  logic [lmsd_pkg::CNT_W-1:0]         col_inc;
  logic                               last_col;
  logic                               pix_ok;
  logic                               pix_lower;
  logic [lmsd_pkg::IN_ROW_W-1:0]      half_row;
  lmsd_pkg::mem_wr_t                  mem_wr;
  lmsd_pkg::mem_rd_t                  mem_rd;
  lmsd_pkg::color_t                   rd_upper;
  lmsd_pkg::color_t                   rd_lower;

  assign in_ch.ready = !mem_busy && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick_acc    = accept && (in_ch.func == lmsd_pkg::FUNC_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r     <= 1'b0;
      dwell_ticks_r <= lmsd_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmsd_pkg::CFG_SCAN_ENABLE: scan_en_r     <= cfg_wdata[0];
        lmsd_pkg::CFG_DWELL_TICKS: dwell_ticks_r <= cfg_wdata[lmsd_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel write address: lower half rows fold onto the same scan row
  assign pix_ok    = (32'(in_ch.pixel_row) < 32'(lmsd_pkg::PANEL_ROWS)) &&
                     (32'(in_ch.pixel_column) < 32'(lmsd_pkg::PANEL_COLUMNS));
  assign pix_lower = 32'(in_ch.pixel_row) >= 32'(lmsd_pkg::SCAN_ROWS);
  assign half_row  = pix_lower ? in_ch.pixel_row - lmsd_pkg::IN_ROW_W'(lmsd_pkg::SCAN_ROWS)
                               : in_ch.pixel_row;

  assign mem_wr.en    = accept && (in_ch.func == lmsd_pkg::FUNC_PIXEL) && pix_ok;
  assign mem_wr.lower = pix_lower;
  assign mem_wr.addr  = lmsd_pkg::ADDR_W'((32'(half_row) << lmsd_pkg::COL_W) |
                                          32'(in_ch.pixel_column));
  assign mem_wr.data  = in_ch.pixel_color;

  assign col_inc  = col_cnt_r + lmsd_pkg::CNT_W'(1);
  assign last_col = col_inc >= lmsd_pkg::CNT_W'(lmsd_pkg::PANEL_COLUMNS);
  assign present  = tick_acc && scan_en_r &&
                    (((phase_r == lmsd_pkg::PH_DWELL) && (dwell_r == '0)) ||
                     (phase_r == lmsd_pkg::PH_DATA));

  assign mem_rd.en   = present;
  assign mem_rd.addr = {scan_row_r, col_cnt_r[lmsd_pkg::COL_W-1:0]};

  lmsd_frame_mem u_frame_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mem_wr),
    .rd       (mem_rd),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .busy     (mem_busy)
  );

  always_comb begin
    phase_nxt = phase_r;
    if (tick_acc) begin
      if (!scan_en_r) begin
        phase_nxt = lmsd_pkg::PH_START;
      end else begin
        unique case (phase_r)
          lmsd_pkg::PH_DWELL:    phase_nxt = (dwell_r == '0) ? lmsd_pkg::PH_CLOCK
                                                             : lmsd_pkg::PH_DWELL;
          lmsd_pkg::PH_DATA:     phase_nxt = lmsd_pkg::PH_CLOCK;
          lmsd_pkg::PH_CLOCK:    phase_nxt = last_col ? lmsd_pkg::PH_LATCH_HI
                                                      : lmsd_pkg::PH_DATA;
          lmsd_pkg::PH_LATCH_HI: phase_nxt = lmsd_pkg::PH_LATCH_LO;
          lmsd_pkg::PH_LATCH_LO: phase_nxt = lmsd_pkg::PH_OE_RISE;
          lmsd_pkg::PH_OE_RISE:  phase_nxt = lmsd_pkg::PH_START;
          default:               phase_nxt = lmsd_pkg::PH_DWELL;
        endcase
      end
    end
  end

  always_comb begin
    scan_row_nxt = scan_row_r;
    col_cnt_nxt  = col_cnt_r;
    dwell_nxt    = dwell_r;
    row_addr_nxt = row_addr_r;
    clk_pin_nxt  = clk_pin_r;
    lat_pin_nxt  = lat_pin_r;
    oe_pin_nxt   = oe_pin_r;
    rgb_live_nxt = rgb_live_r;
    finished_nxt = accept ? 1'b0 : finished_r;
    if (tick_acc) begin
      if (!scan_en_r) begin
        col_cnt_nxt  = '0;
        dwell_nxt    = '0;
        row_addr_nxt = '0;
        clk_pin_nxt  = 1'b0;
        lat_pin_nxt  = 1'b0;
        oe_pin_nxt   = 1'b0;
        rgb_live_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          lmsd_pkg::PH_DWELL: begin
            if (dwell_r != '0) begin
              dwell_nxt = dwell_r - lmsd_pkg::DWELL_W'(1);
            end else begin
              clk_pin_nxt  = 1'b0;
              lat_pin_nxt  = 1'b0;
              rgb_live_nxt = 1'b1;
            end
          end
          lmsd_pkg::PH_DATA: begin
            clk_pin_nxt  = 1'b0;
            lat_pin_nxt  = 1'b0;
            rgb_live_nxt = 1'b1;
          end
          lmsd_pkg::PH_CLOCK: begin
            clk_pin_nxt = 1'b1;
            col_cnt_nxt = col_inc;
          end
          lmsd_pkg::PH_LATCH_HI: begin
            clk_pin_nxt = 1'b0;
            lat_pin_nxt = 1'b1;
          end
          lmsd_pkg::PH_LATCH_LO: begin
            lat_pin_nxt = 1'b0;
          end
          lmsd_pkg::PH_OE_RISE: begin
            oe_pin_nxt   = 1'b1;
            finished_nxt = 1'b1;
            scan_row_nxt = (32'(scan_row_r) == lmsd_pkg::SCAN_ROWS - 1)
                           ? '0 : scan_row_r + lmsd_pkg::ROW_W'(1);
          end
          default: begin
            row_addr_nxt = scan_row_r;
            clk_pin_nxt  = 1'b0;
            lat_pin_nxt  = 1'b0;
            oe_pin_nxt   = 1'b0;
            dwell_nxt    = dwell_ticks_r;
            col_cnt_nxt  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lmsd_pkg::PH_START;
      scan_row_r  <= '0;
      col_cnt_r   <= '0;
      dwell_r     <= '0;
      row_addr_r  <= '0;
      clk_pin_r   <= 1'b0;
      lat_pin_r   <= 1'b0;
      oe_pin_r    <= 1'b0;
      rgb_live_r  <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      scan_row_r <= scan_row_nxt;
      col_cnt_r  <= col_cnt_nxt;
      dwell_r    <= dwell_nxt;
      row_addr_r <= row_addr_nxt;
      clk_pin_r  <= clk_pin_nxt;
      lat_pin_r  <= lat_pin_nxt;
      oe_pin_r   <= oe_pin_nxt;
      rgb_live_r <= rgb_live_nxt;
      finished_r <= finished_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pin state changes only on transfer, so the result reads straight from it
  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_address   = lmsd_pkg::ROW_ADDR_W'(row_addr_r);
  assign out_ch.upper_rgb     = rgb_live_r ? rd_upper : '0;
  assign out_ch.lower_rgb     = rgb_live_r ? rd_lower : '0;
  assign out_ch.shift_clock   = clk_pin_r;
  assign out_ch.latch_strobe  = lat_pin_r;
  assign out_ch.output_enable = oe_pin_r;
  assign out_ch.row_finished  = finished_r;

  `LMSD_ASSERT_NOW(a_clear_blocks_in, mem_busy, !in_ch.ready, "transfer open during clear")
  `LMSD_ASSERT_NEXT(a_finish_raises_oe,
    tick_acc && scan_en_r && (phase_r == lmsd_pkg::PH_OE_RISE),
    out_ch.row_finished && out_ch.output_enable, "row end without OE rise")
  `LMSD_ASSERT_NEXT(a_pixel_holds_phase,
    accept && (in_ch.func == lmsd_pkg::FUNC_PIXEL), $stable(phase_r),
    "pixel write moved the sequencer")
  `LMSD_ASSERT_NOW(a_col_bound, 1'b1,
    col_cnt_r <= lmsd_pkg::CNT_W'(lmsd_pkg::PANEL_COLUMNS), "column count overrun")

endmodule
